### rtl/srfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor response frame checker package
// Shared types, status codes and register indexes for the frame checker.
// ----------------------------------------------------------------------------
package srfc_pkg;

	// Largest frame length in bytes, default for the top level.
	localparam int MAX_FRAME_DEF = 32;

	// Number of leading frame bytes that are held for decoding.
	localparam int HDR_LEN = 6;
	localparam int HDR_IDX_W = 3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COMMAND  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_ERROR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_RESPONSE = 2'd2;

	// Reset values of the type code registers.
	localparam logic [7:0] TYPE_COMMAND_RST  = 8'd17;
	localparam logic [7:0] TYPE_ERROR_RST    = 8'd6;
	localparam logic [7:0] TYPE_RESPONSE_RST = 8'd22;

	// Length of the frame overhead: type, length and checksum bytes.
	localparam int FRAME_OVERHEAD = 3;

	// Frame status codes.
	typedef enum logic [2:0] {
		ST_OK_RESPONSE = 3'd0,
		ST_CMD_ECHO    = 3'd1,
		ST_DEV_ERROR   = 3'd2,
		ST_ERR_UNKNOWN = 3'd3,
		ST_BAD_LENGTH  = 3'd4,
		ST_BAD_CHKSUM  = 3'd5,
		ST_UNKNOWN_TYP = 3'd6
	} frame_status_t;

	// One received byte.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} rx_item_t;

	// One frame result.
	typedef struct packed {
		frame_status_t frame_status;
		logic [7:0]    device_error;
		logic [7:0]    command_echo;
		logic [15:0]   co2_ppm;
		logic          drift_flag;
		logic          light_aging_flag;
		logic          calibrated_flag;
		logic          below_range_flag;
		logic          above_range_flag;
		logic          sensor_fault_flag;
		logic          warming_up_flag;
		logic [5:0]    received_count;
	} frame_result_t;

endpackage

### rtl/sensor_response_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor response frame checker
// Counts, sums and holds the leading bytes of a received response frame and
// gives one checked and decoded result at the end of each frame.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                  | Moves
//  ---------+------------------------------------------+-----------------------
//  byte     | byte_valid, byte_ready, byte_item        | one received byte
//  result   | result_valid, result_ready, result       | one result per frame
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| type code register write
//
// A byte enters the input register at the edge that accepts it, and the frame
// state update writes the result register when a last byte leaves the input
// register. The result stays visible in the result register until it is taken.
// One byte is accepted in every cycle but while the input register waits; it
// waits only while it holds a last byte and the result register is full and not being taken.
// Reset clears the frame state, both valid flags and restores the type codes.
// Configuration writes are always accepted.
module sensor_response_frame_checker
	import srfc_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  rx_item_t             byte_item,

	output logic                 result_valid,
	input  logic                 result_ready,
	output frame_result_t        result,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	// Count width holds the saturation value MAX_FRAME + 1.
	localparam int CW = $clog2(MAX_FRAME + 2);
	// Compare width covers both the count and a length byte plus overhead.
	localparam int CMPW = (CW > 9) ? CW : 9;

	logic [7:0] type_cmd_q;
	logic [7:0] type_err_q;
	logic [7:0] type_rsp_q;

	logic     valid_s1;
	rx_item_t item_s1;
	logic     advance_s1;

	logic [CW-1:0] cnt_q;
	logic [7:0]    sum_q;
	logic [7:0]    hdr_q [HDR_LEN];

	logic [CW-1:0]   cnt_nxt;
	logic [7:0]      sum_nxt;
	logic [7:0]      hdr_nxt [HDR_LEN];
	logic [CMPW-1:0] exp_len;
	logic [CMPW-1:0] cnt_cmp;
	frame_status_t   status;
	logic [7:0]      derr;
	frame_result_t   res_nxt;

	logic          res_valid_s2;
	frame_result_t res_s2;

	// Configuration writes; indexes past the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_cmd_q <= TYPE_COMMAND_RST;
			type_err_q <= TYPE_ERROR_RST;
			type_rsp_q <= TYPE_RESPONSE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TYPE_COMMAND:  type_cmd_q <= cfg_data;
				CFG_TYPE_ERROR:    type_err_q <= cfg_data;
				CFG_TYPE_RESPONSE: type_rsp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A plain byte always moves on; a last byte needs a free result slot.
	assign advance_s1 = !item_s1.frame_end || !res_valid_s2 || result_ready;
	assign byte_ready = !valid_s1 || advance_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	// Frame state after the byte in the input register is counted.
	always_comb begin
		for (int i = 0; i < HDR_LEN; i++) begin
			hdr_nxt[i] = hdr_q[i];
		end
		if (cnt_q < CW'(HDR_LEN)) begin
			hdr_nxt[cnt_q[HDR_IDX_W-1:0]] = item_s1.rx_byte;
		end
		cnt_nxt = (cnt_q < CW'(MAX_FRAME + 1)) ? cnt_q + CW'(1) : cnt_q;
		sum_nxt = sum_q + item_s1.rx_byte;
	end

	// Expected count is the length byte plus overhead, capped at the frame size.
	always_comb begin
		exp_len = CMPW'(hdr_nxt[1]) + CMPW'(FRAME_OVERHEAD);
		if (exp_len > CMPW'(MAX_FRAME)) begin
			exp_len = CMPW'(MAX_FRAME);
		end
		cnt_cmp = CMPW'(cnt_nxt);
	end

	// Checks in order: length, checksum, then type classification.
	always_comb begin
		derr = 8'd0;
		if (cnt_cmp != exp_len) begin
			status = ST_BAD_LENGTH;
		end else if (sum_nxt != 8'd0) begin
			status = ST_BAD_CHKSUM;
		end else if (hdr_nxt[0] == type_cmd_q) begin
			status = ST_CMD_ECHO;
		end else if (hdr_nxt[0] == type_err_q) begin
			if (hdr_nxt[1] == 8'd1) begin
				status = ST_DEV_ERROR;
				derr   = hdr_nxt[3];
			end else begin
				status = ST_ERR_UNKNOWN;
			end
		end else if (hdr_nxt[0] == type_rsp_q) begin
			status = ST_OK_RESPONSE;
		end else begin
			status = ST_UNKNOWN_TYP;
		end
	end

	// Decoded fields but the device error code come from the held bytes whatever the status.
	always_comb begin
		res_nxt.frame_status      = status;
		res_nxt.device_error      = derr;
		res_nxt.command_echo      = hdr_nxt[2];
		res_nxt.co2_ppm           = {hdr_nxt[3], hdr_nxt[4]};
		res_nxt.drift_flag        = hdr_nxt[5][6];
		res_nxt.light_aging_flag  = hdr_nxt[5][5];
		res_nxt.calibrated_flag   = !hdr_nxt[5][4];
		res_nxt.below_range_flag  = hdr_nxt[5][3];
		res_nxt.above_range_flag  = hdr_nxt[5][2];
		res_nxt.sensor_fault_flag = hdr_nxt[5][1];
		res_nxt.warming_up_flag   = !hdr_nxt[5][0];
		res_nxt.received_count    = 6'(cnt_nxt);
	end

	// Frame state registers; a last byte clears them for the next frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			for (int i = 0; i < HDR_LEN; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (valid_s1 && advance_s1) begin
			if (item_s1.frame_end) begin
				cnt_q <= '0;
				sum_q <= '0;
				for (int i = 0; i < HDR_LEN; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				cnt_q <= cnt_nxt;
				sum_q <= sum_nxt;
				for (int i = 0; i < HDR_LEN; i++) begin
					hdr_q[i] <= hdr_nxt[i];
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (valid_s1 && advance_s1 && item_s1.frame_end) begin
			res_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s1 && item_s1.frame_end) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid = res_valid_s2;
	assign result       = res_s2;

endmodule

### rtl/srfc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor response frame checker port checker
// Watches the frame checker's ports over time and flags broken behavior.
// ----------------------------------------------------------------------------
module srfc_chk
	import srfc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_ready,
	input rx_item_t             byte_item,
	input logic                 result_valid,
	input logic                 result_ready,
	input frame_result_t        result
);

	// A stalled result holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The device error code is only given for a device error frame.
	a_derr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_status != ST_DEV_ERROR
		|-> result.device_error == 8'd0)
		else $error("device error code outside a device error result");

	// Status stays within the defined codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.frame_status <= ST_UNKNOWN_TYP)
		else $error("undefined frame status");

	// A new result follows an accepted last byte.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && byte_ready && byte_item.frame_end, 2))
		else $error("result without a last byte");

endmodule

bind sensor_response_frame_checker srfc_chk u_srfc_chk (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor response frame checker testbench
// Streams received bytes into the checker through its valid/ready port,
// predicts each frame result in a behavioral model of the byte count,
// checksum and header decode, and compares every result field by field.
// The run steps through several type code settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
	import srfc_pkg::*;

	localparam int FRAME_MAX = MAX_FRAME_DEF;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 225;
	// Settling time through the checker, with some margin.
	localparam int SETTLE_CYCLES = 6;
	localparam int LIMIT_CYCLES = 200000;
	localparam int REPORT_MAX = 10;
	// Index that selects no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic byte_valid = 1'b0;
	logic byte_ready;
	rx_item_t byte_item = '0;

	logic result_valid;
	logic result_ready = 1'b0;
	frame_result_t result;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	// Stimulus and expectation stores.
	rx_item_t bytes_to_send[$];
	frame_result_t expected_frames[$];
	logic [7:0] frame_bytes[$];

	// Model of the checker state and its type code registers.
	int model_count = 0;
	logic [7:0] model_sum = '0;
	logic [7:0] model_hdr[HDR_LEN] = '{default: '0};
	logic [7:0] code_cmd = TYPE_COMMAND_RST;
	logic [7:0] code_err = TYPE_ERROR_RST;
	logic [7:0] code_rsp = TYPE_RESPONSE_RST;

	// Handshake flags between the monitor and the drivers.
	bit byte_taken = 1'b0;
	bit cfg_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	int cycle_count = 0;
	int fail_count = 0;
	int bytes_accepted = 0;
	int frames_checked = 0;
	int status_seen[7] = '{default: 0};

	sensor_response_frame_checker #(
		.MAX_FRAME(FRAME_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Update the frame model with one accepted byte; at a frame end, queue
	// the decoded result and clear the frame state.
	task automatic absorb_byte(input rx_item_t it);
		int want;
		logic [7:0] flags;
		frame_result_t r;
		if (model_count < HDR_LEN)
			model_hdr[model_count] = it.rx_byte;
		if (model_count < FRAME_MAX + 1)
			model_count++;
		model_sum = model_sum + it.rx_byte;
		if (it.frame_end) begin
			want = int'(model_hdr[1]) + FRAME_OVERHEAD;
			if (want > FRAME_MAX)
				want = FRAME_MAX;
			r = '0;
			// Length first, then checksum, then type; the first type match wins.
			if (model_count != want) begin
				r.frame_status = ST_BAD_LENGTH;
			end else if (model_sum != 8'd0) begin
				r.frame_status = ST_BAD_CHKSUM;
			end else if (model_hdr[0] == code_cmd) begin
				r.frame_status = ST_CMD_ECHO;
			end else if (model_hdr[0] == code_err) begin
				// An error frame counts as a device error only when its length byte is one.
				if (model_hdr[1] == 8'd1) begin
					r.frame_status = ST_DEV_ERROR;
					r.device_error = model_hdr[3];
				end else begin
					r.frame_status = ST_ERR_UNKNOWN;
				end
			end else if (model_hdr[0] == code_rsp) begin
				r.frame_status = ST_OK_RESPONSE;
			end else begin
				r.frame_status = ST_UNKNOWN_TYP;
			end
			flags = model_hdr[5];
			r.command_echo = model_hdr[2];
			r.co2_ppm = {model_hdr[3], model_hdr[4]};
			r.drift_flag = flags[6];
			r.light_aging_flag = flags[5];
			r.calibrated_flag = ~flags[4];
			r.below_range_flag = flags[3];
			r.above_range_flag = flags[2];
			r.sensor_fault_flag = flags[1];
			r.warming_up_flag = ~flags[0];
			r.received_count = 6'(model_count);
			expected_frames.push_back(r);
			model_count = 0;
			model_sum = '0;
			model_hdr = '{default: '0};
		end
	endtask

	// Monitor: sample every handshake at the rising edge.
	always @(posedge clk) begin : monitor
		frame_result_t want_res;
		bit bad;
		cycle_count++;
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				absorb_byte(byte_item);
				byte_taken = 1'b1;
				bytes_accepted++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TYPE_COMMAND: code_cmd = cfg_data;
					CFG_TYPE_ERROR: code_err = cfg_data;
					CFG_TYPE_RESPONSE: code_rsp = cfg_data;
					default: ;
				endcase
				cfg_taken = 1'b1;
			end
			if (result_valid && result_ready) begin
				if (expected_frames.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected result %h at cycle %0d", result, cycle_count);
				end else begin
					want_res = expected_frames.pop_front();
					frames_checked++;
					status_seen[want_res.frame_status]++;
					bad = (result.frame_status !== want_res.frame_status)
						|| (result.device_error !== want_res.device_error)
						|| (result.command_echo !== want_res.command_echo)
						|| (result.co2_ppm !== want_res.co2_ppm)
						|| (result.drift_flag !== want_res.drift_flag)
						|| (result.light_aging_flag !== want_res.light_aging_flag)
						|| (result.calibrated_flag !== want_res.calibrated_flag)
						|| (result.below_range_flag !== want_res.below_range_flag)
						|| (result.above_range_flag !== want_res.above_range_flag)
						|| (result.sensor_fault_flag !== want_res.sensor_fault_flag)
						|| (result.warming_up_flag !== want_res.warming_up_flag)
						|| (result.received_count !== want_res.received_count);
					if (bad) begin
						fail_count++;
						if (fail_count <= REPORT_MAX) begin
							$display("frame %0d mismatch at cycle %0d", frames_checked,
								cycle_count);
							$display("  expected status %0d err %h cmd %h co2 %h flags %b count %0d",
								want_res.frame_status, want_res.device_error,
								want_res.command_echo, want_res.co2_ppm,
								want_res[12:6], want_res.received_count);
							$display("  actual   status %0d err %h cmd %h co2 %h flags %b count %0d",
								result.frame_status, result.device_error,
								result.command_echo, result.co2_ppm,
								result[12:6], result.received_count);
						end
					end
				end
			end
		end
	end

	// Driver: present requests and the result ready at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			result_ready <= 1'b0;
		end else begin
			if (!byte_valid || byte_taken) begin
				if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_valid <= 1'b1;
					byte_item <= bytes_to_send.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
			byte_taken = 1'b0;
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Append the checksum if asked, optionally spoiled, and queue the frame.
	task automatic ship_frame(input bit seal, input bit spoil);
		logic [7:0] total;
		rx_item_t it;
		if (seal) begin
			total = '0;
			foreach (frame_bytes[i])
				total = total + frame_bytes[i];
			total = 8'd0 - total;
			if (spoil)
				total = total + 8'($urandom_range(1, 255));
			frame_bytes.push_back(total);
		end
		foreach (frame_bytes[i]) begin
			it.rx_byte = frame_bytes[i];
			it.frame_end = (i == frame_bytes.size() - 1);
			bytes_to_send.push_back(it);
		end
		frame_bytes.delete();
	endtask

	// Write one type code register and wait for the write to be taken.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_taken = 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// Hold the sender until every queued byte is in and every result is out.
	task automatic wait_drained();
		do @(posedge clk);
		while (bytes_to_send.size() > 0 || byte_valid || expected_frames.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Queue random frames: mostly well formed, some with a wrong length or
	// checksum, and some loose bytes with random frame ends.
	task automatic fill_phase(input int n_items);
		int queued;
		int pick;
		int kind;
		int fit;
		int nbytes;
		int body;
		logic [7:0] ftype;
		logic [7:0] flen;
		rx_item_t it;
		queued = 0;
		while (queued < n_items) begin
			pick = $urandom_range(3);
			case (pick)
				0: ftype = code_cmd;
				1: ftype = code_err;
				2: ftype = code_rsp;
				default: ftype = 8'($urandom_range(255));
			endcase
			flen = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
			if (pick == 1 && $urandom_range(1) == 1)
				flen = 8'd1;
			fit = int'(flen) + FRAME_OVERHEAD;
			if (fit > FRAME_MAX)
				fit = FRAME_MAX;
			kind = $urandom_range(99);
			nbytes = fit;
			if (kind >= 65 && kind < 78) begin
				// Wrong byte count, past saturation at times.
				do nbytes = $urandom_range(1, FRAME_MAX + 6); while (nbytes == fit);
			end
			if (kind >= 90) begin
				nbytes = $urandom_range(1, 6);
				for (int i = 0; i < nbytes; i++) begin
					it.rx_byte = 8'($urandom_range(255));
					it.frame_end = (i == nbytes - 1) || ($urandom_range(3) == 0);
					bytes_to_send.push_back(it);
				end
			end else begin
				body = (nbytes >= 3) ? nbytes - 1 : nbytes;
				frame_bytes.push_back(ftype);
				if (body > 1)
					frame_bytes.push_back(flen);
				for (int i = 2; i < body; i++)
					frame_bytes.push_back(8'($urandom_range(255)));
				ship_frame(nbytes >= 3,
					(kind >= 78) || (kind >= 65 && $urandom_range(1) == 1));
			end
			queued += nbytes;
		end
	endtask

	// Stimulus sequence.
	initial begin : stimulus
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed frames under the reset type codes.
		frame_bytes = {TYPE_RESPONSE_RST, 8'd1, 8'd0};
		ship_frame(1'b1, 1'b0);
		frame_bytes = {TYPE_COMMAND_RST, 8'd1, 8'd255};
		ship_frame(1'b1, 1'b0);
		// The checksum doubles as the error code byte; this command makes it zero.
		frame_bytes = {TYPE_ERROR_RST, 8'd1, 8'(8'd0 - TYPE_ERROR_RST - 8'd1)};
		ship_frame(1'b1, 1'b0);
		// Error frame whose length byte is not one.
		frame_bytes = {TYPE_ERROR_RST, 8'd0};
		ship_frame(1'b1, 1'b0);
		// A lone byte: a short frame with empty header bytes.
		frame_bytes = {8'd255};
		ship_frame(1'b0, 1'b0);
		frame_bytes = {TYPE_RESPONSE_RST, 8'd1, 8'h5a};
		ship_frame(1'b1, 1'b1);
		frame_bytes = {8'd255, 8'd3, 8'd0, 8'd255, 8'd0};
		ship_frame(1'b1, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				case (p)
					1: begin
						cfg_write(CFG_TYPE_COMMAND, 8'd0);
						cfg_write(CFG_TYPE_ERROR, 8'd0);
						cfg_write(CFG_TYPE_RESPONSE, 8'd0);
					end
					2: begin
						cfg_write(CFG_TYPE_COMMAND, 8'd255);
						cfg_write(CFG_TYPE_ERROR, 8'd128);
						cfg_write(CFG_TYPE_RESPONSE, 8'd1);
						cfg_write(CFG_SPARE, 8'($urandom_range(255)));
					end
					3: begin
						cfg_write(CFG_TYPE_COMMAND, 8'd255);
						cfg_write(CFG_TYPE_ERROR, 8'd255);
						cfg_write(CFG_TYPE_RESPONSE, 8'd255);
					end
					4: begin
						// Error and response share a code; error must win.
						cfg_write(CFG_TYPE_COMMAND, 8'($urandom_range(255)));
						cfg_write(CFG_TYPE_ERROR, 8'd6);
						cfg_write(CFG_TYPE_RESPONSE, 8'd6);
					end
					5: begin
						cfg_write(CFG_TYPE_COMMAND, TYPE_COMMAND_RST);
						cfg_write(CFG_TYPE_ERROR, TYPE_ERROR_RST);
						cfg_write(CFG_TYPE_RESPONSE, TYPE_RESPONSE_RST);
					end
					default: begin
						cfg_write(CFG_TYPE_COMMAND, 8'($urandom_range(255)));
						cfg_write(CFG_TYPE_ERROR, 8'($urandom_range(255)));
						cfg_write(CFG_TYPE_RESPONSE, 8'($urandom_range(255)));
					end
				endcase
			end
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct = 29;
					recv_stall_pct = 29;
				end
			endcase
			fill_phase(ITEMS_PER_PHASE);
		end

		wait_drained();
		if (expected_frames.size() != 0)
			fail_count++;
		$display("Sent %0d bytes and checked %0d frames over %0d code settings and idle mixes.",
			bytes_accepted, frames_checked, PHASES);
		$display("Statuses seen: ok %0d, echo %0d, dev err %0d, err unknown %0d, length %0d, sum %0d, type %0d",
			status_seen[ST_OK_RESPONSE], status_seen[ST_CMD_ECHO], status_seen[ST_DEV_ERROR],
			status_seen[ST_ERR_UNKNOWN], status_seen[ST_BAD_LENGTH],
			status_seen[ST_BAD_CHKSUM], status_seen[ST_UNKNOWN_TYP]);
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// Watchdog on the cycle count.
	initial begin : watchdog
		wait (cycle_count >= LIMIT_CYCLES);
		$display("testbench NOT OK");
		$finish;
	end

endmodule

### sensor_response_frame_checker.f
rtl/srfc_pkg.sv
rtl/sensor_response_frame_checker.sv
rtl/srfc_chk.sv
tb/testbench.sv
